FILE: hdl/retransmit_timeout_tracker_defines.svh
// Assertion macros shared by the retransmit timeout tracker RTL.
`ifndef RETRANSMIT_TIMEOUT_TRACKER_DEFINES_SVH
`define RETRANSMIT_TIMEOUT_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rtt_pkg.sv
// Types, constants and codes for the retransmit timeout tracker.
package rtt_pkg;

	localparam int SLOTS      = 8;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W       = 16;
	localparam int AGE_W      = 16;
	localparam int RETRY_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIMEOUT = 1'd1;

	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST     = 8'd3;
	localparam logic [AGE_W-1:0]   CONFIRM_TIMEOUT_RST = 16'd250;

	typedef enum logic [1:0] {
		OP_SEND    = 2'd0,
		OP_CONFIRM = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_ASSIGNED = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_MATCHED  = 3'd2,
		KIND_UNKNOWN  = 3'd3,
		KIND_RESEND   = 3'd4,
		KIND_DROPPED  = 3'd5
	} kind_t;

	// Configuration seen by every cell
	typedef struct packed {
		logic [RETRY_W-1:0] limit;
		logic [AGE_W-1:0]   timeout;
	} cfg_t;

	// Request token that walks the chain, collecting what the cells report
	typedef struct packed {
		logic             v;
		op_t              op;
		logic [ID_W-1:0]  id;
		logic             hit;
		logic             stale_f;
		logic [IDX_W-1:0] stale_idx;
		logic             free_f;
		logic [IDX_W-1:0] free_idx;
	} tok_t;

	// Expiry event raised by a cell during a tick
	typedef struct packed {
		logic            v;
		kind_t           kind;
		logic [ID_W-1:0] id;
	} ev_t;

	// Slot fill from the controller
	typedef struct packed {
		logic            en;
		logic [ID_W-1:0] id;
	} wr_t;

endpackage

FILE: hdl/rtt_cell.sv
// One table slot of the tracker with its stage of the request chain.
module rtt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rtt_pkg::IDX_W-1:0] idx,
	input  logic                      adv,
	input  rtt_pkg::cfg_t             cfg,
	input  rtt_pkg::wr_t              wr,
	input  rtt_pkg::tok_t             tok_in,
	output rtt_pkg::tok_t             tok_out,
	output rtt_pkg::ev_t              ev
);
	import rtt_pkg::*;

	logic               valid_q;
	logic [ID_W-1:0]    id_q;
	logic [AGE_W-1:0]   age_q;
	logic [RETRY_W-1:0] retries_q;
	tok_t               tok_q;

	logic [AGE_W-1:0]   age_inc;
	logic [RETRY_W-1:0] retries_inc;
	logic               expired;
	logic               out_of_retries;
	logic               id_hit;
	logic               step;

	// Slot evaluation against the request held in this stage
	always_comb begin
		age_inc        = (age_q == '1) ? age_q : age_q + 1'b1;
		retries_inc    = (retries_q == '1) ? retries_q : retries_q + 1'b1;
		expired        = (age_inc >= cfg.timeout);
		out_of_retries = (retries_q >= cfg.limit);
		id_hit         = valid_q && (id_q == tok_q.id);
		step           = adv && tok_q.v;
		tok_out        = tok_q;
		ev             = '0;
		if (tok_q.v) begin
			case (tok_q.op)
				OP_SEND: begin
					if (id_hit && !tok_q.stale_f) begin
						tok_out.stale_f   = 1'b1;
						tok_out.stale_idx = idx;
					end
					if (!valid_q && !tok_q.free_f) begin
						tok_out.free_f   = 1'b1;
						tok_out.free_idx = idx;
					end
				end
				OP_CONFIRM: begin
					if (id_hit) tok_out.hit = 1'b1;
				end
				OP_TICK: begin
					if (valid_q && expired) begin
						ev.v    = 1'b1;
						ev.kind = out_of_retries ? KIND_DROPPED : KIND_RESEND;
						ev.id   = id_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Chain stage and slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) tok_q <= tok_in;
			if (wr.en) begin
				valid_q <= 1'b1;
			end else if (step) begin
				case (tok_q.op)
					OP_CONFIRM: if (id_hit) valid_q <= 1'b0;
					OP_TICK:    if (valid_q && expired && out_of_retries) valid_q <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	// Slot payload: id, age, retry count
	always_ff @(posedge clk) begin
		if (wr.en) begin
			id_q      <= wr.id;
			age_q     <= '0;
			retries_q <= '0;
		end else if (step && valid_q && (tok_q.op == OP_TICK)) begin
			if (!expired) begin
				age_q <= age_inc;
			end else if (!out_of_retries) begin
				age_q     <= '0;
				retries_q <= retries_inc;
			end
		end
	end

endmodule

FILE: hdl/retransmit_timeout_tracker.sv
// A request walks the chain of SLOTS cells at one cell per cycle while the chain is not held,
// then is finished. Send and confirm results pass the finish register and then the output
// register; each tick result is held until the next expiry or the chain end, where the last
// one is sent. A new request is accepted only once the previous one has finished (in_stall high).
// Reset (arst_n low, asynchronous): all slots free, next id 0, retry limit 3, timeout 250.
`include "retransmit_timeout_tracker_defines.svh"
module retransmit_timeout_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic [rtt_pkg::ID_W-1:0]       confirm_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     kind,
	output logic [rtt_pkg::ID_W-1:0]       msg_id,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rtt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rtt_pkg::*;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic            last;
	} res_t;

	cfg_t            cfg_q;
	logic            busy_q;
	logic [ID_W-1:0] next_id_q;
	tok_t            fin_q;
	logic            pend_v_q;
	ev_t             pend_q;
	logic            out_v_q;
	res_t            out_q;

	tok_t             tok_c [SLOTS+1];
	ev_t              ev_c  [SLOTS];
	wr_t              wr_c  [SLOTS];
	logic [SLOTS-1:0] ev_v_vec;
	logic [SLOTS-1:0] tok_v_vec;
	ev_t              ev_any;

	logic             accept;
	logic             out_busy;
	logic             adv;
	logic             fin_go;
	logic             out_load;
	res_t             out_nxt;
	logic             pend_clr;
	logic             wr_go;
	logic [IDX_W-1:0] wr_idx;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign out_busy  = out_v_q && out_stall;
	assign out_valid = out_v_q;
	assign kind      = out_q.kind;
	assign msg_id    = out_q.id;
	assign last      = out_q.last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit   <= RETRY_LIMIT_RST;
			cfg_q.timeout <= CONFIRM_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RETRY_LIMIT:     cfg_q.limit   <= cfg_data[RETRY_W-1:0];
				REG_CONFIRM_TIMEOUT: cfg_q.timeout <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Request token entering the chain
	always_comb begin
		tok_c[0]    = '0;
		tok_c[0].v  = accept;
		tok_c[0].op = op_t'(opcode);
		tok_c[0].id = (op_t'(opcode) == OP_SEND) ? next_id_q : confirm_id;
	end

	// Row of slot cells
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		assign wr_c[g].en    = wr_go && (wr_idx == IDX_W'(g));
		assign wr_c[g].id    = next_id_q;
		assign ev_v_vec[g]   = ev_c[g].v;
		assign tok_v_vec[g]  = tok_c[g+1].v;

		rtt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(g)),
			.adv     (adv),
			.cfg     (cfg_q),
			.wr      (wr_c[g]),
			.tok_in  (tok_c[g]),
			.tok_out (tok_c[g+1]),
			.ev      (ev_c[g])
		);
	end

	// At most one cell raises an event, so an OR merges them
	always_comb begin
		ev_any = '0;
		for (int i = 0; i < SLOTS; i++) ev_any = ev_any | ev_c[i];
	end

	// Chain holds when a result has nowhere to go
	assign adv    = !((ev_any.v && pend_v_q && out_busy) || (fin_q.v && out_busy));
	assign fin_go = fin_q.v && !out_busy;

	// Result routing and finishing the request
	always_comb begin
		out_load = 1'b0;
		out_nxt  = '0;
		pend_clr = 1'b0;
		wr_go    = 1'b0;
		wr_idx   = fin_q.stale_f ? fin_q.stale_idx : fin_q.free_idx;
		if (adv && ev_any.v && pend_v_q) begin
			out_load     = 1'b1;
			out_nxt.kind = pend_q.kind;
			out_nxt.id   = pend_q.id;
		end
		if (fin_go) begin
			case (fin_q.op)
				OP_SEND: begin
					out_load     = 1'b1;
					out_nxt.id   = next_id_q;
					out_nxt.last = 1'b1;
					wr_go        = fin_q.stale_f || fin_q.free_f;
					out_nxt.kind = wr_go ? KIND_ASSIGNED : KIND_FULL;
				end
				OP_CONFIRM: begin
					out_load     = 1'b1;
					out_nxt.id   = fin_q.id;
					out_nxt.last = 1'b1;
					out_nxt.kind = fin_q.hit ? KIND_MATCHED : KIND_UNKNOWN;
				end
				OP_TICK: begin
					if (pend_v_q) begin
						out_load     = 1'b1;
						out_nxt.kind = pend_q.kind;
						out_nxt.id   = pend_q.id;
						out_nxt.last = 1'b1;
						pend_clr     = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			next_id_q <= '0;
			fin_q     <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (accept) busy_q <= 1'b1;
			else if (fin_go) busy_q <= 1'b0;
			if (wr_go) next_id_q <= next_id_q + 1'b1;
			if (adv) fin_q <= tok_c[SLOTS];
			if (adv && ev_any.v) pend_v_q <= 1'b1;
			else if (pend_clr) pend_v_q <= 1'b0;
			if (out_load) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
		end
	end

	// Held event and output payload
	always_ff @(posedge clk) begin
		if (adv && ev_any.v) pend_q <= ev_any;
		if (out_load) out_q <= out_nxt;
	end

	`RTT_ASSERT_IMP(a_one_event, 1'b1, $onehot0(ev_v_vec), "two cells raised an event")
	`RTT_ASSERT_IMP(a_one_token, 1'b1, $onehot0({tok_v_vec, fin_q.v}), "more than one request in the chain")
	`RTT_ASSERT_IMP(a_accept_empty, accept, (tok_v_vec == '0) && !fin_q.v && !pend_v_q, "request accepted while chain busy")
	`RTT_ASSERT_NXT(a_busy_after_accept, accept, busy_q, "busy not set after accept")
	`RTT_ASSERT_IMP(a_pend_busy, pend_v_q, busy_q && (fin_q.op == OP_TICK || !fin_q.v), "held event outside a tick")

endmodule

FILE: tb/sv/retransmit_timeout_tracker_checker.sv
// Watches the tracker's channels, predicts its results and compares them in order.
module retransmit_timeout_tracker_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic [rtt_pkg::ID_W-1:0]       confirm_id,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [2:0]                     kind,
	input  logic [rtt_pkg::ID_W-1:0]       msg_id,
	input  logic                           last,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rtt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtt_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding,
	output logic [rtt_pkg::ID_W-1:0]       id_next,
	output int                             n_req,
	output int                             n_res,
	output int                             n_expiry
);
	timeunit 1ns;
	timeprecision 1ps;
	import rtt_pkg::*;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic            last;
	} result_t;

	// Predicted table contents and settings
	logic               slot_live  [SLOTS];
	logic [ID_W-1:0]    slot_tag   [SLOTS];
	logic [AGE_W-1:0]   slot_age   [SLOTS];
	logic [RETRY_W-1:0] slot_tries [SLOTS];
	logic [RETRY_W-1:0] limit_reg;
	logic [AGE_W-1:0]   timeout_reg;

	result_t pending_results [$];

	// Apply one accepted request to the predicted table and queue its results
	task automatic track_request(input logic [1:0] opc, input logic [ID_W-1:0] cid);
		result_t batch [SLOTS];
		result_t r;
		int n;
		int target;
		logic hit;
		n = 0;
		target = -1;
		hit = 1'b0;
		case (opc)
		OP_SEND: begin
			// a live entry already holding the id wins over the lowest free slot
			for (int i = 0; i < SLOTS; i++)
				if (target < 0 && slot_live[i] && slot_tag[i] == id_next)
					target = i;
			for (int i = 0; i < SLOTS; i++)
				if (target < 0 && !slot_live[i])
					target = i;
			if (target < 0) begin
				batch[n] = '{KIND_FULL, id_next, 1'b0};
			end else begin
				slot_live[target]  = 1'b1;
				slot_tag[target]   = id_next;
				slot_age[target]   = '0;
				slot_tries[target] = '0;
				batch[n] = '{KIND_ASSIGNED, id_next, 1'b0};
				id_next = id_next + 1'b1;
			end
			n++;
		end
		OP_CONFIRM: begin
			for (int i = 0; i < SLOTS; i++)
				if (slot_live[i] && slot_tag[i] == cid) begin
					slot_live[i] = 1'b0;
					hit = 1'b1;
				end
			batch[n] = '{hit ? KIND_MATCHED : KIND_UNKNOWN, cid, 1'b0};
			n++;
		end
		OP_TICK: begin
			// age every live entry, then resend or drop the ones that timed out
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_live[i]) begin
					if (slot_age[i] != '1)
						slot_age[i] = slot_age[i] + 1'b1;
					if (slot_age[i] >= timeout_reg) begin
						if (slot_tries[i] >= limit_reg) begin
							slot_live[i] = 1'b0;
							batch[n] = '{KIND_DROPPED, slot_tag[i], 1'b0};
						end else begin
							slot_age[i] = '0;
							if (slot_tries[i] != '1)
								slot_tries[i] = slot_tries[i] + 1'b1;
							batch[n] = '{KIND_RESEND, slot_tag[i], 1'b0};
						end
						n++;
						n_expiry++;
					end
				end
			end
		end
		default: begin
		end
		endcase
		for (int k = 0; k < n; k++) begin
			r = batch[k];
			r.last = (k == n - 1);
			pending_results = {pending_results, r};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_live[i]  = 1'b0;
				slot_tag[i]   = '0;
				slot_age[i]   = '0;
				slot_tries[i] = '0;
			end
			limit_reg   = RETRY_LIMIT_RST;
			timeout_reg = CONFIRM_TIMEOUT_RST;
			id_next     = '0;
			pending_results.delete();
			mismatches  = 0;
			outstanding = 0;
			n_req       = 0;
			n_res       = 0;
			n_expiry    = 0;
		end else begin
			// results first, so a request taken on this edge cannot satisfy them
			if (out_valid && !out_stall) begin
				n_res++;
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result, expected none, got kind %0d id %0d last %0b",
						$time, kind, msg_id, last);
				end else begin
					result_t want;
					want = pending_results.pop_front();
					if (kind !== want.kind || msg_id !== want.id || last !== want.last) begin
						mismatches++;
						$display("%0t ns: result mismatch, expected kind %0d id %0d last %0b,",
							$time, want.kind, want.id, want.last);
						$display("    got kind %0d id %0d last %0b", kind, msg_id, last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				n_req++;
				track_request(opcode, confirm_id);
			end
			// register writes should land only while the block is idle; neither the block nor this checker enforces it
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_RETRY_LIMIT:     limit_reg   = cfg_data[RETRY_W-1:0];
				REG_CONFIRM_TIMEOUT: timeout_reg = cfg_data[AGE_W-1:0];
				default: begin
				end
				endcase
			end
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: tb/sv/retransmit_timeout_tracker_tb.sv
// Top of the tracker testbench: clock, reset, stimulus phases and verdict.
module retransmit_timeout_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rtt_pkg::*;

	localparam logic [1:0] OP_IGNORED  = 2'd3;
	localparam int         CYCLE_LIMIT = 200_000;
	localparam int         SETTLE      = 2 * (SLOTS + 2);
	localparam int         PHASE_ITEMS = 31;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            opcode;
	logic [ID_W-1:0]       confirm_id;
	logic                  out_valid;
	logic                  out_stall;
	logic [2:0]            kind;
	logic [ID_W-1:0]       msg_id;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int              mismatches;
	int              outstanding;
	logic [ID_W-1:0] id_next;
	int              n_req;
	int              n_res;
	int              n_expiry;
	int              idle_pct;
	int              stall_pct;
	int              cycles = 0;

	// Per-phase handshake pressure and timer settings
	int idle_plan    [4] = '{0, 64, 0, 37};
	int stall_plan   [4] = '{0, 0, 64, 37};
	int limit_plan   [4] = '{2, 0, 1, 4};
	int timeout_plan [4] = '{3, 1, 2, 5};

	retransmit_timeout_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.confirm_id (confirm_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.msg_id     (msg_id),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	retransmit_timeout_tracker_checker u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.confirm_id  (confirm_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.msg_id      (msg_id),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.id_next     (id_next),
		.n_req       (n_req),
		.n_res       (n_res),
		.n_expiry    (n_expiry)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result-side backpressure
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycles, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one request, with random idle cycles ahead of it; returns at a falling edge
	task automatic issue(input logic [1:0] op, input logic [ID_W-1:0] id);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		opcode     = op;
		confirm_id = id;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Wait until every predicted result is back, then let a ticking pass finish
	task automatic settle();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Retry limit goes out with noise in the unused upper bits
	task automatic set_policy(input int limit, input int tmo);
		settle();
		write_reg(REG_RETRY_LIMIT, {8'($urandom_range(255)), 8'(limit)});
		write_reg(REG_CONFIRM_TIMEOUT, 16'(tmo));
	endtask

	// Mixed traffic; most confirms target recently assigned ids
	task automatic random_item();
		int pick;
		logic [ID_W-1:0] cid;
		pick = $urandom_range(99);
		if (pick < 40) begin
			issue(OP_SEND, 16'($urandom_range(65535)));
		end else if (pick < 70) begin
			if ($urandom_range(3) == 0)
				cid = 16'($urandom_range(65535));
			else
				cid = id_next - 16'($urandom_range(1, SLOTS + 2));
			issue(OP_CONFIRM, cid);
		end else if (pick < 98) begin
			issue(OP_TICK, 16'($urandom_range(65535)));
		end else begin
			issue(OP_IGNORED, 16'($urandom_range(65535)));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OP_SEND;
		confirm_id = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_RETRY_LIMIT;
		cfg_data   = '0;
		idle_pct   = 0;
		stall_pct  = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, unused opcode, fill to full, confirm twice
		issue(OP_CONFIRM, 16'hFFFF);
		issue(OP_CONFIRM, 16'h0000);
		issue(OP_IGNORED, 16'hFFFF);
		issue(OP_TICK, 16'h0000);
		repeat (SLOTS) issue(OP_SEND, 16'h0000);
		issue(OP_SEND, 16'hFFFF);
		issue(OP_CONFIRM, 16'd3);
		issue(OP_CONFIRM, 16'd3);
		issue(OP_SEND, 16'h5555);
		issue(OP_TICK, 16'hAAAA);

		// every slot resends on one tick, then every slot drops
		set_policy(1, 1);
		issue(OP_TICK, 16'h0000);
		issue(OP_TICK, 16'h0000);

		// zero timeout: every live entry expires on each tick
		set_policy(2, 0);
		issue(OP_SEND, 16'h0000);
		issue(OP_SEND, 16'h0000);
		repeat (3) issue(OP_TICK, 16'h0000);

		set_policy(255, 65535);
		issue(OP_SEND, 16'h0000);
		issue(OP_TICK, 16'h0000);

		// Random traffic under each pressure mix
		for (int p = 0; p < 4; p++) begin
			set_policy(limit_plan[p], timeout_plan[p]);
			idle_pct  = idle_plan[p];
			stall_pct = stall_plan[p];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 1 && k == PHASE_ITEMS / 2)
					settle();
				random_item();
			end
		end
		settle();

		$display("Covered %0d requests and %0d checked results (%0d resends or drops)",
			n_req, n_res, n_expiry);
		$display("across four backpressure mixes, a full table and extreme timer settings.");
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
